@@ rtl/rmt_pkg.sv @@
// rmt_pkg: shared types and constants of the repeat message tracker
// no dependencies; used by repeat_message_tracker
package rmt_pkg;

    localparam int unsigned NUM_USERS_DEF = 64;
    localparam int unsigned HISTORY_DEF   = 8;
    localparam int unsigned SHORT_PERIOD  = 6;

    localparam logic [7:0] RPT_THRESH_RST = 8'd3;
    localparam logic [7:0] COUNT_MAX      = 8'hFF;

    // register index, taken from paddr[2]
    localparam logic REG_RPT_THRESH = 1'b0;

    typedef enum logic [1:0] {
        VERDICT_NONE   = 2'd0,
        VERDICT_WARN   = 2'd1,
        VERDICT_SEVERE = 2'd2
    } t_verdict;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_END
    } t_state;

    typedef struct packed {
        logic [31:0] hash;
        logic [31:0] ts;
        logic [7:0]  count;
    } t_entry;

endpackage

@@ rtl/rmt_ram.sv @@
// rmt_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module rmt_ram #(
    parameter int unsigned WIDTH = 72,
    parameter int unsigned DEPTH = 512,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/repeat_message_tracker.sv @@
// repeat_message_tracker: per-user repeat message detector on one history ram
// depends on rmt_pkg and rmt_ram
//
// channel   | signals                                             | handshake
// ----------+-----------------------------------------------------+--------------------------
// item in   | i_user_slot, i_msg_hash, i_short_message,           | taken when start && !busy
//           | i_now_seconds                                       |
// result    | o_verdict                                           | o_verdict_valid, 1 cycle
// config    | psel, penable, pwrite, paddr, pwdata, prdata, pready| apb, pready tied high
//
// an item walks the user's HISTORY entries one per cycle: the ram read of the
// next entry overlaps the check and write back of the current one
// busy stays high from accept through the scan and end states (scan stops early on an
// early verdict, out of range user skips scan); verdict beat follows in the next cycle
// after reset a clearing pass writes zero to all NUM_USERS*HISTORY entries,
// one per cycle, with busy high; config writes are taken during the pass
// the result beat cannot be stalled: o_verdict_valid is high for one cycle
module repeat_message_tracker #(
    parameter int unsigned NUM_USERS = rmt_pkg::NUM_USERS_DEF,
    parameter int unsigned HISTORY   = rmt_pkg::HISTORY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item channel
    input  logic        start,
    output logic        busy,
    input  logic [5:0]  i_user_slot,
    input  logic [31:0] i_msg_hash,
    input  logic        i_short_message,
    input  logic [31:0] i_now_seconds,
    // result channel
    output logic        o_verdict_valid,
    output logic [1:0]  o_verdict,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned DEPTH   = NUM_USERS * HISTORY;
    localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned IW      = (HISTORY > 1) ? $clog2(HISTORY) : 1;
    localparam int unsigned ENTRY_W = $bits(rmt_pkg::t_entry);

    // fsm and datapath registers
    rmt_pkg::t_state   r_state, n_state;
    logic [31:0]       r_hash, n_hash;
    logic [31:0]       r_now, n_now;
    logic              r_short, n_short;
    logic [AW-1:0]     r_addr, n_addr;
    logic [IW-1:0]     r_idx, n_idx;
    logic              r_matched, n_matched;
    logic              r_have_free, n_have_free;
    logic [AW-1:0]     r_free_addr, n_free_addr;
    logic [AW-1:0]     r_clr_addr, n_clr_addr;
    logic [7:0]        r_limit;
    logic              r_out_valid, n_out_valid;
    rmt_pkg::t_verdict r_verdict, n_verdict;

    // ram ports
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    rmt_pkg::t_entry   ram_wdata;
    logic [AW-1:0]     ram_raddr;
    rmt_pkg::t_entry   rd_entry;
    logic [ENTRY_W-1:0] rd_bits;

    // entry evaluation
    logic [31:0]       base_full;
    logic [AW-1:0]     base_addr;
    logic              in_range;
    logic              accept;
    logic              last_idx;
    logic [32:0]       age;
    logic [31:0]       period;
    logic              stale;
    logic              is_free;
    logic              hit;
    logic [7:0]        cnt_inc;
    rmt_pkg::t_verdict hit_verdict;
    logic              cfg_wr;

    // first entry of the requested user: multiply by a constant
    assign base_full = 32'(i_user_slot) * 32'(HISTORY);
    assign base_addr = base_full[AW-1:0];
    assign in_range  = 32'(i_user_slot) < 32'(NUM_USERS);
    assign accept    = start && !busy;
    assign last_idx  = (r_idx == IW'(HISTORY - 1));

    assign rd_entry = rmt_pkg::t_entry'(rd_bits);

    // exact signed age: negative when time went backwards, never stale then
    assign age    = {1'b0, r_now} - {1'b0, rd_entry.ts};
    assign period = r_short ? 32'(rmt_pkg::SHORT_PERIOD) : 32'(HISTORY);
    assign stale  = !age[32] && (age[31:0] > period);

    // a zero hash marks a free entry and never matches
    assign is_free = stale || (rd_entry.hash == 32'd0);
    assign hit     = !is_free && (rd_entry.hash == r_hash);

    // saturating repeat count
    assign cnt_inc = (rd_entry.count == rmt_pkg::COUNT_MAX) ? rmt_pkg::COUNT_MAX
                                                            : rd_entry.count + 8'd1;

    always_comb begin
        if (cnt_inc > r_limit) begin
            hit_verdict = rmt_pkg::VERDICT_SEVERE;
        end else if (cnt_inc == r_limit) begin
            hit_verdict = rmt_pkg::VERDICT_WARN;
        end else begin
            hit_verdict = rmt_pkg::VERDICT_NONE;
        end
    end

    // next state and datapath
    always_comb begin
        n_state     = r_state;
        n_hash      = r_hash;
        n_now       = r_now;
        n_short     = r_short;
        n_addr      = r_addr;
        n_idx       = r_idx;
        n_matched   = r_matched;
        n_have_free = r_have_free;
        n_free_addr = r_free_addr;
        n_clr_addr  = r_clr_addr;
        unique case (r_state)
            rmt_pkg::ST_CLEAR: begin
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = rmt_pkg::ST_IDLE;
                end
            end
            rmt_pkg::ST_IDLE: begin
                if (start) begin
                    n_hash      = i_msg_hash;
                    n_now       = i_now_seconds;
                    n_short     = i_short_message;
                    n_addr      = base_addr;
                    n_idx       = '0;
                    n_matched   = 1'b0;
                    n_have_free = 1'b0;
                    // out of range user: straight to a none verdict, no insert
                    n_state     = in_range ? rmt_pkg::ST_SCAN : rmt_pkg::ST_END;
                end
            end
            rmt_pkg::ST_SCAN: begin
                if (is_free) begin
                    n_have_free = 1'b1;
                    n_free_addr = r_addr;
                end
                if (hit) begin
                    n_matched = 1'b1;
                end
                if (hit && (hit_verdict != rmt_pkg::VERDICT_NONE)) begin
                    // early end: later entries untouched
                    n_state = rmt_pkg::ST_IDLE;
                end else if (last_idx) begin
                    n_state = rmt_pkg::ST_END;
                end else begin
                    n_idx  = r_idx + IW'(1);
                    n_addr = r_addr + AW'(1);
                end
            end
            rmt_pkg::ST_END: begin
                n_state = rmt_pkg::ST_IDLE;
            end
            default: begin
                n_state = rmt_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs: ram controls, result beat, busy
    always_comb begin
        busy        = (r_state != rmt_pkg::ST_IDLE);
        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = rd_entry;
        ram_raddr   = r_addr;
        n_out_valid = 1'b0;
        n_verdict   = rmt_pkg::VERDICT_NONE;
        unique case (r_state)
            rmt_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
            end
            rmt_pkg::ST_IDLE: begin
                ram_raddr = base_addr;
            end
            rmt_pkg::ST_SCAN: begin
                // prefetch the next entry while this one is written back
                ram_raddr = last_idx ? r_addr : r_addr + AW'(1);
                if (stale) begin
                    ram_we         = 1'b1;
                    ram_wdata.hash = 32'd0;
                end else if (hit) begin
                    ram_we          = 1'b1;
                    ram_wdata.ts    = r_now;
                    ram_wdata.count = cnt_inc;
                end
                if (hit && (hit_verdict != rmt_pkg::VERDICT_NONE)) begin
                    n_out_valid = 1'b1;
                    n_verdict   = hit_verdict;
                end
            end
            rmt_pkg::ST_END: begin
                // insert into the last free entry when nothing matched
                ram_we          = !r_matched && r_have_free;
                ram_waddr       = r_free_addr;
                ram_wdata.hash  = r_hash;
                ram_wdata.ts    = r_now;
                ram_wdata.count = 8'd1;
                n_out_valid     = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rmt_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_verdict   <= rmt_pkg::VERDICT_NONE;
            r_matched   <= 1'b0;
            r_have_free <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
            r_verdict   <= n_verdict;
            r_matched   <= n_matched;
            r_have_free <= n_have_free;
            r_idx       <= n_idx;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_hash      <= n_hash;
        r_now       <= n_now;
        r_short     <= n_short;
        r_addr      <= n_addr;
        r_free_addr <= n_free_addr;
    end

    // config register
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == rmt_pkg::REG_RPT_THRESH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= rmt_pkg::RPT_THRESH_RST;
        end else if (cfg_wr) begin
            r_limit <= pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == rmt_pkg::REG_RPT_THRESH) ? {24'd0, r_limit} : 32'd0;

    assign o_verdict_valid = r_out_valid;
    assign o_verdict       = r_verdict;

    rmt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (1'b1),
        .i_raddr (ram_raddr),
        .o_rdata (rd_bits)
    );

    // a result beat always closes an item that kept the block busy
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_verdict_valid |-> $past(busy))
        else $error("result beat without a preceding busy cycle");

    // warning or severe only comes from a matching entry in the scan
    a_verdict_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_verdict_valid && (o_verdict != rmt_pkg::VERDICT_NONE))
        |-> $past(r_state == rmt_pkg::ST_SCAN))
        else $error("nonzero verdict not caused by a scan hit");

    // the history is never written while idle
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rmt_pkg::ST_IDLE) |-> !ram_we)
        else $error("history write while idle");

    // an accepted item always makes the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted item did not raise busy");

endmodule
